@@ src/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
// No dependencies; every other file in src uses this package.
`timescale 1ns / 1ps

package spq_pkg;

   localparam int unsigned DEPTH       = 16;
   localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
   localparam int unsigned PRIO_W      = 16;
   localparam int unsigned AMT_W       = 8;
   localparam int unsigned TIME_W      = 16;
   localparam int unsigned COUNT_OUT_W = 5;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_REMOVE = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_INSERTED  = 2'd0,
      STATUS_REMOVED   = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_EMPTY     = 2'd3
   } status_type;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [AMT_W-1:0]  amount;
      logic [TIME_W-1:0] etime;
   } entry_type;

   // Operation broadcast to every cell of the chain.
   typedef struct packed {
      logic      ins;
      logic      rem;
      entry_type ent;
   } cmd_type;

endpackage

@@ src/spq_if.sv @@
// Valid/ready channel interfaces for request and response words.
// Depends on spq_pkg.
`timescale 1ns / 1ps

interface spq_req_if;
   logic                       valid;
   logic                       ready;
   spq_pkg::kind_type          kind;
   logic [spq_pkg::PRIO_W-1:0] entry_priority;
   logic [spq_pkg::AMT_W-1:0]  entry_amount;
   logic [spq_pkg::TIME_W-1:0] entry_time;

   modport source (output valid, kind, entry_priority, entry_amount, entry_time,
                   input ready);
   modport sink   (input valid, kind, entry_priority, entry_amount, entry_time,
                   output ready);
endinterface

interface spq_rsp_if;
   logic                            valid;
   logic                            ready;
   spq_pkg::status_type             status;
   logic [spq_pkg::PRIO_W-1:0]      removed_priority;
   logic [spq_pkg::AMT_W-1:0]       removed_amount;
   logic [spq_pkg::TIME_W-1:0]      removed_time;
   logic [spq_pkg::COUNT_OUT_W-1:0] entry_count;

   modport source (output valid, status, removed_priority, removed_amount,
                   removed_time, entry_count, input ready);
   modport sink   (input valid, status, removed_priority, removed_amount,
                   removed_time, entry_count, output ready);
endinterface

@@ src/spq_cell.sv @@
// One slot of the sorted chain: holds an entry, shifts with its neighbors.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cell (
   input  logic               clock,
   input  spq_pkg::cmd_type   cmd,
   input  logic               occupied,   // slot index below the count
   input  logic               left_ge,    // left neighbor stays put on insert
   input  spq_pkg::entry_type left_ent,
   input  spq_pkg::entry_type right_ent,
   output logic               ge,
   output spq_pkg::entry_type ent
);

   spq_pkg::entry_type ent_ff;
   spq_pkg::entry_type ent_in;

   // Occupied with priority >= new one: this entry keeps its slot on insert.
   assign ge  = occupied & (ent_ff.prio >= cmd.ent.prio);
   assign ent = ent_ff;

   always_comb begin
      ent_in = ent_ff;
      if (cmd.ins) begin
         if (ge) begin
            ent_in = ent_ff;
         end else if (left_ge) begin
            ent_in = cmd.ent;
         end else begin
            ent_in = left_ent;
         end
      end else if (cmd.rem) begin
         ent_in = right_ent;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

endmodule

@@ src/sorted_priority_queue.sv @@
// Bounded priority queue kept sorted, highest priority first, in a chain of
// DEPTH cells; equal priorities leave oldest first. Each request word
// (insert or remove) yields one response word with a status and the entry
// count after the operation. Every cell compares against the broadcast entry
// and all cells shift together; a new request is accepted every cycle in which
// the response register is free or its response word is taken. Insert into a
// full queue and remove from an empty one are rejected with no change.
// Depends on spq_pkg, spq_if and spq_cell.
`timescale 1ns / 1ps

module sorted_priority_queue (
   input  logic          clock,
   input  logic          reset,
   spq_req_if.sink       req_chan,
   spq_rsp_if.source     rsp_chan
);

   logic [spq_pkg::CNT_W-1:0] count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   spq_pkg::status_type       status_ff, status_in;
   spq_pkg::entry_type        removed_ff, removed_in;

   spq_pkg::cmd_type          cmd;
   spq_pkg::entry_type        cell_ent [spq_pkg::DEPTH];
   logic [spq_pkg::DEPTH-1:0] cell_ge;
   logic [spq_pkg::DEPTH-1:0] occupied;

   logic req_acc, full, empty, do_ins, do_rem;

   assign req_chan.ready = ~rsp_valid_ff | rsp_chan.ready;
   assign req_acc        = req_chan.valid & req_chan.ready;
   assign full           = (count_ff == spq_pkg::CNT_W'(spq_pkg::DEPTH));
   assign empty          = (count_ff == '0);
   assign do_ins         = req_acc & (req_chan.kind == spq_pkg::KIND_INSERT) & ~full;
   assign do_rem         = req_acc & (req_chan.kind == spq_pkg::KIND_REMOVE) & ~empty;

   assign cmd.ins         = do_ins;
   assign cmd.rem         = do_rem;
   assign cmd.ent.prio    = req_chan.entry_priority;
   assign cmd.ent.amount  = req_chan.entry_amount;
   assign cmd.ent.etime   = req_chan.entry_time;

   for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
      assign occupied[i] = (count_ff > spq_pkg::CNT_W'(i));

      logic               l_ge;
      spq_pkg::entry_type l_ent, r_ent;

      if (i == 0) begin : g_head
         assign l_ge  = 1'b1;
         assign l_ent = cmd.ent;
      end else begin : g_mid
         assign l_ge  = cell_ge[i-1];
         assign l_ent = cell_ent[i-1];
      end

      // tail shifts in don't-care data on remove; it is outside the count
      if (i == spq_pkg::DEPTH - 1) begin : g_tail
         assign r_ent = cell_ent[i];
      end else begin : g_body
         assign r_ent = cell_ent[i+1];
      end

      spq_cell u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .occupied  (occupied[i]),
         .left_ge   (l_ge),
         .left_ent  (l_ent),
         .right_ent (r_ent),
         .ge        (cell_ge[i]),
         .ent       (cell_ent[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (do_ins) begin
         count_in = count_ff + 1'b1;
      end else if (do_rem) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      status_in    = status_ff;
      removed_in   = removed_ff;
      if (req_acc) begin
         rsp_valid_in = 1'b1;
         removed_in   = '0;
         if (req_chan.kind == spq_pkg::KIND_INSERT) begin
            status_in = full ? spq_pkg::STATUS_FULL : spq_pkg::STATUS_INSERTED;
         end else if (empty) begin
            status_in = spq_pkg::STATUS_EMPTY;
         end else begin
            status_in  = spq_pkg::STATUS_REMOVED;
            removed_in = cell_ent[0];
         end
      end
   end

   logic [spq_pkg::COUNT_OUT_W-1:0] count_out_ff, count_out_in;
   assign count_out_in = req_acc ? spq_pkg::COUNT_OUT_W'(count_in) : count_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      removed_ff   <= removed_in;
      count_out_ff <= count_out_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = status_ff;
   assign rsp_chan.removed_priority = removed_ff.prio;
   assign rsp_chan.removed_amount   = removed_ff.amount;
   assign rsp_chan.removed_time     = removed_ff.etime;
   assign rsp_chan.entry_count      = count_out_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= spq_pkg::CNT_W'(spq_pkg::DEPTH))
      else $error("entry count above depth");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      do_ins |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not bump the count");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      count_ff >= spq_pkg::CNT_W'(2) |-> cell_ent[0].prio >= cell_ent[1].prio)
      else $error("chain head out of order");

   a_empty_reject: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_chan.kind == spq_pkg::KIND_REMOVE && empty
      |=> rsp_valid_ff && status_ff == spq_pkg::STATUS_EMPTY && count_ff == '0)
      else $error("remove from empty not rejected");

endmodule
